// File: sv/spu_pkg.sv
`timescale 1ns / 1ps

package spu_pkg;

  localparam int ADDR_BITS = 16;
  localparam int MEM_DEPTH = 2 ** ADDR_BITS;
  localparam int SP_W      = 16;
  localparam int VAL_W     = 64;
  localparam int WORD_W    = 16;
  localparam int SEG_W     = 4;
  localparam int PSW_W     = 8;
  localparam int BYTE_W    = 8;
  localparam int NB_W      = 4;
  localparam int LIST_W    = 4;
  localparam int ACT_W     = 2;
  localparam int MAX_BYTES = 8;
  localparam int SLOT_N    = 6;
  localparam int SLOT_W    = 8;
  localparam int SEL_W     = 3;
  localparam int CNT_W     = 4;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;

  localparam logic [ACT_W-1:0] ACT_PUSH      = 2'd0;
  localparam logic [ACT_W-1:0] ACT_POP       = 2'd1;
  localparam logic [ACT_W-1:0] ACT_PUSH_LIST = 2'd2;
  localparam logic [ACT_W-1:0] ACT_POP_LIST  = 2'd3;

  localparam logic [0:0] REG_LARGE_MODEL = 1'b0;

  // list bits
  localparam int LB_EA  = 0;
  localparam int LB_PC  = 1;
  localparam int LB_PSW = 2;
  localparam int LB_LR  = 3;

  // push slots, in store order
  localparam logic [SEL_W-1:0] PS_ECSR = 3'd0;
  localparam logic [SEL_W-1:0] PS_ELR  = 3'd1;
  localparam logic [SEL_W-1:0] PS_EPSW = 3'd2;
  localparam logic [SEL_W-1:0] PS_LCSR = 3'd3;
  localparam logic [SEL_W-1:0] PS_LR   = 3'd4;
  localparam logic [SEL_W-1:0] PS_EA   = 3'd5;

  // pop slots, in restore order
  localparam logic [SEL_W-1:0] PP_EA   = 3'd0;
  localparam logic [SEL_W-1:0] PP_LR   = 3'd1;
  localparam logic [SEL_W-1:0] PP_LCSR = 3'd2;
  localparam logic [SEL_W-1:0] PP_PSW  = 3'd3;
  localparam logic [SEL_W-1:0] PP_PC   = 3'd4;
  localparam logic [SEL_W-1:0] PP_CSR  = 3'd5;

  typedef struct packed {
    logic             start;
    logic             load_out;
    logic             we;
    logic             re;
    logic             up;
    logic [SEL_W-1:0] sel;
    logic             hi;
  } spu_cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0]  act;
    logic [NB_W-1:0]   nbytes;
    logic [SLOT_W-1:0] slots;
  } spu_sts_t;

endpackage

// File: sv/spu_if.sv
`timescale 1ns / 1ps

interface spu_in_if import spu_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACT_W-1:0]    action;
  logic [NB_W-1:0]     reg_bytes;
  logic [LIST_W-1:0]   reg_list;
  logic [VAL_W-1:0]    push_value;
  logic [WORD_W-1:0]   ea_in;
  logic [WORD_W-1:0]   lr_in;
  logic [SEG_W-1:0]    lcsr_in;
  logic [WORD_W-1:0]   elr_in;
  logic [SEG_W-1:0]    ecsr_in;
  logic [PSW_W-1:0]    epsw_in;

  modport source (
    output valid, action, reg_bytes, reg_list, push_value, ea_in, lr_in, lcsr_in,
           elr_in, ecsr_in, epsw_in,
    input  ready
  );

  modport sink (
    input  valid, action, reg_bytes, reg_list, push_value, ea_in, lr_in, lcsr_in,
           elr_in, ecsr_in, epsw_in,
    output ready
  );
endinterface

interface spu_out_if import spu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [VAL_W-1:0]  pop_value;
  logic [WORD_W-1:0] ea_out;
  logic [WORD_W-1:0] lr_out;
  logic [SEG_W-1:0]  lcsr_out;
  logic [WORD_W-1:0] psw_out;
  logic [WORD_W-1:0] pc_out;
  logic [SEG_W-1:0]  csr_out;
  logic [SP_W-1:0]   sp_out;

  modport source (
    output valid, pop_value, ea_out, lr_out, lcsr_out, psw_out, pc_out, csr_out, sp_out,
    input  ready
  );

  modport sink (
    input  valid, pop_value, ea_out, lr_out, lcsr_out, psw_out, pc_out, csr_out, sp_out,
    output ready
  );
endinterface

// File: sv/spu_ctrl.sv
`timescale 1ns / 1ps

module spu_ctrl import spu_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     out_ready_i,
  output logic     out_valid_o,
  input  spu_sts_t sts_i,
  output spu_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_CAPT = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             half_q, half_d;
  logic             out_valid_q, out_valid_d;
  spu_cmd_t         cmd;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    half_d     = half_q;
    cmd        = '0;
    in_ready_o = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.start = 1'b1;
          cnt_d     = '0;
          half_d    = 1'b0;
          state_d   = S_RUN;
        end
      end
      S_RUN: begin
        if (!sts_i.act[1]) begin
          // single register: one byte per cycle, ascending
          if (cnt_q < sts_i.nbytes) begin
            cmd.we  = (sts_i.act == ACT_PUSH);
            cmd.re  = (sts_i.act == ACT_POP);
            cmd.up  = 1'b1;
            cmd.sel = cnt_q[SEL_W-1:0];
            cnt_d   = cnt_q + 1'b1;
          end else begin
            state_d = S_CAPT;
          end
        end else begin
          // register list: two bytes per enabled slot, skip the rest
          if (cnt_q >= CNT_W'(SLOT_N)) begin
            state_d = S_CAPT;
          end else if (sts_i.slots[cnt_q[SEL_W-1:0]]) begin
            cmd.we  = (sts_i.act == ACT_PUSH_LIST);
            cmd.re  = (sts_i.act == ACT_POP_LIST);
            cmd.up  = (sts_i.act == ACT_POP_LIST);
            cmd.sel = cnt_q[SEL_W-1:0];
            cmd.hi  = (sts_i.act == ACT_PUSH_LIST) ? ~half_q : half_q;
            half_d  = ~half_q;
            if (half_q) begin
              cnt_d = cnt_q + 1'b1;
            end
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      S_CAPT: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.load_out = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      half_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      half_q      <= half_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cmd_o       = cmd;
  assign out_valid_o = out_valid_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RUN |-> cnt_q <= CNT_W'(MAX_BYTES))
    else $error("step counter out of range");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while held");

  a_mem_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.we && cmd.re))
    else $error("memory write and read in one cycle");

endmodule

// File: sv/spu_dpath.sv
`timescale 1ns / 1ps

module spu_dpath import spu_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  spu_cmd_t       cmd_i,
  input  logic           large_i,
  spu_in_if.sink         item_i,
  spu_out_if.source      res_o,
  output spu_sts_t       sts_o
);

  logic [BYTE_W-1:0] mem [MEM_DEPTH];

  logic [ACT_W-1:0]  act_q;
  logic [NB_W-1:0]   nb_q;
  logic [SLOT_W-1:0] slots_q;
  logic [SP_W-1:0]   sp_q;
  logic [SP_W-1:0]   ptr_q;
  logic [VAL_W-1:0]  pv_q;
  logic [WORD_W-1:0] ea_q, lr_q, elr_q;
  logic [SEG_W-1:0]  lcsr_q, ecsr_q;
  logic [PSW_W-1:0]  epsw_q;

  logic [VAL_W-1:0]  popv_q;
  logic [WORD_W-1:0] eao_q, lro_q, pswo_q, pco_q;
  logic [SEG_W-1:0]  lcsro_q, csro_q;

  logic [VAL_W-1:0]  o_pop_q;
  logic [WORD_W-1:0] o_ea_q, o_lr_q, o_psw_q, o_pc_q;
  logic [SEG_W-1:0]  o_lcsr_q, o_csr_q;
  logic [SP_W-1:0]   o_sp_q;

  logic [BYTE_W-1:0] rdata_q;
  logic              rvld_q;
  logic [SEL_W-1:0]  rsel_q;
  logic              rhi_q;

  logic [NB_W-1:0]      nb_sat;
  logic [SP_W-1:0]      move;
  logic [SLOT_W-1:0]    slots_in;
  logic [SEL_W-1:0]     word_cnt;
  logic [SP_W-1:0]      list_move;
  logic [SP_W-1:0]      sp_d;
  logic [SP_W-1:0]      ptr_start;
  logic [WORD_W-1:0]    wword;
  logic [BYTE_W-1:0]    wbyte;
  logic [ADDR_BITS-1:0] addr;

  always_comb begin
    nb_sat = (item_i.reg_bytes > NB_W'(MAX_BYTES)) ? NB_W'(MAX_BYTES) : item_i.reg_bytes;
    move   = (nb_sat == NB_W'(1)) ? SP_W'(2) : SP_W'(nb_sat);

    slots_in = '0;
    if (item_i.action == ACT_PUSH_LIST) begin
      slots_in[PS_ECSR] = item_i.reg_list[LB_PC] & large_i;
      slots_in[PS_ELR]  = item_i.reg_list[LB_PC];
      slots_in[PS_EPSW] = item_i.reg_list[LB_PSW];
      slots_in[PS_LCSR] = item_i.reg_list[LB_LR] & large_i;
      slots_in[PS_LR]   = item_i.reg_list[LB_LR];
      slots_in[PS_EA]   = item_i.reg_list[LB_EA];
    end else begin
      slots_in[PP_EA]   = item_i.reg_list[LB_EA];
      slots_in[PP_LR]   = item_i.reg_list[LB_LR];
      slots_in[PP_LCSR] = item_i.reg_list[LB_LR] & large_i;
      slots_in[PP_PSW]  = item_i.reg_list[LB_PSW];
      slots_in[PP_PC]   = item_i.reg_list[LB_PC];
      slots_in[PP_CSR]  = item_i.reg_list[LB_PC] & large_i;
    end
    word_cnt  = SEL_W'($countones(slots_in));
    list_move = SP_W'({word_cnt, 1'b0});

    case (item_i.action)
      ACT_PUSH: begin
        sp_d      = sp_q - move;
        ptr_start = sp_q - move;
      end
      ACT_POP: begin
        sp_d      = sp_q + move;
        ptr_start = sp_q;
      end
      ACT_PUSH_LIST: begin
        sp_d      = sp_q - list_move;
        ptr_start = sp_q - SP_W'(1);
      end
      ACT_POP_LIST: begin
        sp_d      = sp_q + list_move;
        ptr_start = sp_q;
      end
      default: begin
        sp_d      = sp_q;
        ptr_start = sp_q;
      end
    endcase
  end

  always_comb begin
    case (cmd_i.sel)
      PS_ECSR: wword = WORD_W'(ecsr_q);
      PS_ELR:  wword = elr_q;
      PS_EPSW: wword = WORD_W'(epsw_q);
      PS_LCSR: wword = WORD_W'(lcsr_q);
      PS_LR:   wword = lr_q;
      PS_EA:   wword = ea_q;
      default: wword = '0;
    endcase
    if (act_q == ACT_PUSH) begin
      wbyte = pv_q[{cmd_i.sel, 3'b000} +: BYTE_W];
    end else begin
      wbyte = cmd_i.hi ? wword[WORD_W-1:BYTE_W] : wword[BYTE_W-1:0];
    end
  end

  assign addr = ptr_q[ADDR_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      mem[addr] <= wbyte;
    end
    if (cmd_i.re) begin
      rdata_q <= mem[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q   <= ACT_PUSH;
      nb_q    <= '0;
      slots_q <= '0;
      sp_q    <= '0;
      rvld_q  <= 1'b0;
    end else begin
      rvld_q <= cmd_i.re;
      if (cmd_i.start) begin
        act_q   <= item_i.action;
        nb_q    <= nb_sat;
        slots_q <= slots_in;
        sp_q    <= sp_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rsel_q <= cmd_i.sel;
    rhi_q  <= cmd_i.hi;
    if (cmd_i.start) begin
      ptr_q  <= ptr_start;
      pv_q   <= item_i.push_value;
      ea_q   <= item_i.ea_in;
      lr_q   <= item_i.lr_in;
      lcsr_q <= item_i.lcsr_in;
      elr_q  <= item_i.elr_in;
      ecsr_q <= item_i.ecsr_in;
      epsw_q <= item_i.epsw_in;
    end else if (cmd_i.we || cmd_i.re) begin
      ptr_q <= cmd_i.up ? ptr_q + SP_W'(1) : ptr_q - SP_W'(1);
    end
  end

  // gather popped bytes in the cycle after each read
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      popv_q  <= '0;
      eao_q   <= '0;
      lro_q   <= '0;
      lcsro_q <= '0;
      pswo_q  <= '0;
      pco_q   <= '0;
      csro_q  <= '0;
    end else if (rvld_q) begin
      if (act_q == ACT_POP) begin
        popv_q[{rsel_q, 3'b000} +: BYTE_W] <= rdata_q;
      end else begin
        case (rsel_q)
          PP_EA: begin
            if (rhi_q) eao_q[WORD_W-1:BYTE_W] <= rdata_q;
            else       eao_q[BYTE_W-1:0]      <= rdata_q;
          end
          PP_LR: begin
            if (rhi_q) lro_q[WORD_W-1:BYTE_W] <= rdata_q;
            else       lro_q[BYTE_W-1:0]      <= rdata_q;
          end
          PP_LCSR: begin
            if (!rhi_q) lcsro_q <= rdata_q[SEG_W-1:0];
          end
          PP_PSW: begin
            if (rhi_q) pswo_q[WORD_W-1:BYTE_W] <= rdata_q;
            else       pswo_q[BYTE_W-1:0]      <= rdata_q;
          end
          PP_PC: begin
            if (rhi_q) pco_q[WORD_W-1:BYTE_W] <= rdata_q;
            else       pco_q[BYTE_W-1:0]      <= rdata_q;
          end
          PP_CSR: begin
            if (!rhi_q) csro_q <= rdata_q[SEG_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      o_pop_q  <= popv_q;
      o_ea_q   <= eao_q;
      o_lr_q   <= lro_q;
      o_lcsr_q <= lcsro_q;
      o_psw_q  <= pswo_q;
      o_pc_q   <= pco_q;
      o_csr_q  <= csro_q;
      o_sp_q   <= sp_q;
    end
  end

  assign res_o.pop_value = o_pop_q;
  assign res_o.ea_out    = o_ea_q;
  assign res_o.lr_out    = o_lr_q;
  assign res_o.lcsr_out  = o_lcsr_q;
  assign res_o.psw_out   = o_psw_q;
  assign res_o.pc_out    = o_pc_q;
  assign res_o.csr_out   = o_csr_q;
  assign res_o.sp_out    = o_sp_q;

  assign sts_o.act    = act_q;
  assign sts_o.nbytes = nb_q;
  assign sts_o.slots  = slots_q;

  a_rd_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.re |=> rvld_q)
    else $error("read tag lost");

  a_we_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.we |-> (act_q == ACT_PUSH || act_q == ACT_PUSH_LIST))
    else $error("memory write outside a push");

endmodule

// File: sv/stack_push_pop_unit.sv
`timescale 1ns / 1ps

// Stack push/pop unit with its own byte-wide stack memory and 16-bit stack pointer.
// item_i carries one stack operation per word: single-register push or pop of 1 to 8
// bytes, or a register-list push or pop. result_o returns one word per operation with
// the popped values (zero where nothing was loaded) and the new stack pointer.
// large_model sits at APB address 0; write it only while no operation is in flight.
// A single-register op of N bytes (sizes above eight count as eight) moves one byte
// per step; a list op moves W words (up to 6) and walks all six slots; both then pass
// through the capture and done states. An item is accepted only while the unit is
// idle, so each operation finishes before the next one starts. The single memory port,
// one byte per cycle, and the walk over all six list slots set how long each op runs.
// The next item is accepted once the result sits in the output register, so a
// held result does not block the following operation until that one finishes.
// When result_o stalls, the finished result stays valid and unchanged until taken.
// Reset clears the stack pointer and large_model; memory contents are undefined.

module stack_push_pop_unit import spu_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  spu_in_if.sink            item_i,
  spu_out_if.source         result_o
);

  logic     large_q;
  logic     cfg_hit;
  logic     in_ready;
  logic     out_valid;
  spu_cmd_t cmd;
  spu_sts_t sts;

  assign cfg_hit = (paddr[CFG_AW-1:2] == REG_LARGE_MODEL);
  assign pready  = 1'b1;
  assign prdata  = cfg_hit ? {{(CFG_DW-1){1'b0}}, large_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      large_q <= 1'b0;
    end else if (psel && penable && pwrite && cfg_hit) begin
      large_q <= pwdata[0];
    end
  end

  spu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (in_ready),
    .out_ready_i (result_o.ready),
    .out_valid_o (out_valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  spu_dpath u_dpath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .large_i (large_q),
    .item_i  (item_i),
    .res_o   (result_o),
    .sts_o   (sts)
  );

  assign item_i.ready   = in_ready;
  assign result_o.valid = out_valid;

endmodule
